// File: hdl/fcca_pkg.sv
// Shared types, codes and defaults for the FAT16 cluster chain allocator.
package fcca_pkg;

  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int MAX_CHAIN_DEF     = 64;

  localparam int REQ_W   = 3;
  localparam int ST_W    = 3;
  localparam int CLUS_W  = 16;
  localparam int LEN_W   = 7;
  localparam int FREED_W = 13;
  localparam int COUNT_W = 12;
  localparam int CFG_W   = 12;
  localparam int CIDX_W  = 1;

  localparam logic [REQ_W-1:0] REQ_WRITE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FIND  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ALLOC = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FREE  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE  = 3'd1;
  localparam logic [ST_W-1:0] ST_READONLY = 3'd2;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [ST_W-1:0] ST_TOOLONG  = 3'd4;

  localparam logic [CLUS_W-1:0] EOC_MIN   = 16'hFFF8;
  localparam logic [CLUS_W-1:0] EOC_LAST  = 16'hFFFF;
  localparam logic [CLUS_W-1:0] LINK_FREE = 16'h0000;

  localparam logic [CIDX_W-1:0] REG_COUNT    = 1'b0;
  localparam logic [CIDX_W-1:0] REG_WRITABLE = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_RST = 12'd4094;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               writable;
  } cfg_t;

endpackage

// File: hdl/fcca_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
module fcca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/fcca_engine.sv
// Request sequencer: table clear, scans, chain build, rollback and chain walk.
module fcca_engine #(
  parameter int TABLE_ENTRIES = fcca_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CHAIN     = fcca_pkg::MAX_CHAIN_DEF,
  localparam int IW = $clog2(TABLE_ENTRIES),
  localparam int BW = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fcca_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [fcca_pkg::REQ_W-1:0]   in_req_type,
  input  logic [fcca_pkg::CLUS_W-1:0]  in_cluster_index,
  input  logic [fcca_pkg::CLUS_W-1:0]  in_entry_value,
  input  logic [fcca_pkg::LEN_W-1:0]   in_chain_length,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fcca_pkg::ST_W-1:0]    out_status,
  output logic [fcca_pkg::CLUS_W-1:0]  out_result_cluster,
  output logic [fcca_pkg::CLUS_W-1:0]  out_read_value,
  output logic [fcca_pkg::FREED_W-1:0] out_freed_count,
  output logic                         out_last,
  output logic                         t_we,
  output logic [IW-1:0]                t_waddr,
  output logic [fcca_pkg::CLUS_W-1:0]  t_wdata,
  output logic [IW-1:0]                t_raddr,
  input  logic [fcca_pkg::CLUS_W-1:0]  t_rdata,
  output logic                         b_we,
  output logic [BW-1:0]                b_waddr,
  output logic [IW-1:0]                b_wdata,
  output logic [BW-1:0]                b_raddr,
  input  logic [IW-1:0]                b_rdata
);

  import fcca_pkg::*;

  localparam int CW = $clog2(MAX_CHAIN + 1);
  localparam int FW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [16:0] TE_V  = 17'(TABLE_ENTRIES);
  localparam logic [IW-1:0] CLR_END = IW'(TABLE_ENTRIES - 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_ANEXT = 4'd4;
  localparam logic [3:0] S_AEND  = 4'd5;
  localparam logic [3:0] S_UNDO  = 4'd6;
  localparam logic [3:0] S_ORD   = 4'd7;
  localparam logic [3:0] S_OEMIT = 4'd8;
  localparam logic [3:0] S_FWALK = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  localparam logic [1:0] W_DONE  = 2'd0;
  localparam logic [1:0] W_RANGE = 2'd1;
  localparam logic [1:0] W_LONG  = 2'd2;
  localparam logic [1:0] W_GO    = 2'd3;

  function automatic logic [1:0] walk_step(input logic [CLUS_W-1:0] cand,
                                           input logic [FW-1:0] freed);
    logic [1:0] d;
    if (cand < 16'd2 || cand >= EOC_MIN) begin
      d = W_DONE;
    end else if ({1'b0, cand} >= TE_V) begin
      d = W_RANGE;
    end else if (17'(freed) >= TE_V) begin
      d = W_LONG;
    end else begin
      d = W_GO;
    end
    return d;
  endfunction

  logic [3:0]        state_r, state_nxt;
  logic [IW-1:0]     clr_r, clr_nxt;
  logic [16:0]       scan_c_r, scan_c_nxt;
  logic              pend_r, pend_nxt;
  logic [IW-1:0]     pend_c_r, pend_c_nxt;
  logic              alloc_r, alloc_nxt;
  logic [IW-1:0]     prev_r, prev_nxt;
  logic              has_prev_r, has_prev_nxt;
  logic [IW-1:0]     link_from_r, link_from_nxt;
  logic              link_pend_r, link_pend_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [CW-1:0]     len_r, len_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic              upend_r, upend_nxt;
  logic [IW-1:0]     walk_c_r, walk_c_nxt;
  logic [FW-1:0]     freed_r, freed_nxt;
  logic              byp_r, byp_nxt;
  logic [ST_W-1:0]   res_status_r, res_status_nxt;
  logic [CLUS_W-1:0] res_cluster_r, res_cluster_nxt;
  logic [CLUS_W-1:0] res_rv_r, res_rv_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]    out_status_r, out_status_nxt;
  logic [CLUS_W-1:0]  out_cluster_r, out_cluster_nxt;
  logic [CLUS_W-1:0]  out_rv_r, out_rv_nxt;
  logic [FREED_W-1:0] out_freed_r, out_freed_nxt;
  logic               out_last_r, out_last_nxt;

  logic              out_free;
  logic              accept;
  logic              in_range;
  logic [16:0]       lim_sum;
  logic [16:0]       lim;
  logic              hit;
  logic [CLUS_W-1:0] walk_data;
  logic [FW-1:0]     freed_inc;
  logic [1:0]        walk_dec;
  logic [1:0]        walk_dec0;
  logic              out_is_last;

  assign in_stall    = (state_r != S_IDLE);
  assign accept      = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign in_range    = ({1'b0, in_cluster_index} < TE_V);
  assign lim_sum     = 17'(cfg.count) + 17'd2;
  assign lim         = (lim_sum > TE_V) ? TE_V : lim_sum;
  assign hit         = pend_r && (t_rdata == LINK_FREE);
  assign walk_data   = byp_r ? LINK_FREE : t_rdata;
  assign freed_inc   = FW'(freed_r + 1'b1);
  assign walk_dec    = walk_step(walk_data, freed_inc);
  assign walk_dec0   = walk_step(in_cluster_index, FW'(0));
  assign out_is_last = (CW'(j_r + 1'b1) == fill_r);

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    scan_c_nxt      = scan_c_r;
    pend_nxt        = pend_r;
    pend_c_nxt      = pend_c_r;
    alloc_nxt       = alloc_r;
    prev_nxt        = prev_r;
    has_prev_nxt    = has_prev_r;
    link_from_nxt   = link_from_r;
    link_pend_nxt   = link_pend_r;
    fill_nxt        = fill_r;
    len_nxt         = len_r;
    j_nxt           = j_r;
    upend_nxt       = upend_r;
    walk_c_nxt      = walk_c_r;
    freed_nxt       = freed_r;
    byp_nxt         = byp_r;
    res_status_nxt  = res_status_r;
    res_cluster_nxt = res_cluster_r;
    res_rv_nxt      = res_rv_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_cluster_nxt = out_cluster_r;
    out_rv_nxt      = out_rv_r;
    out_freed_nxt   = out_freed_r;
    out_last_nxt    = out_last_r;
    t_we            = 1'b0;
    t_waddr         = walk_c_r;
    t_wdata         = LINK_FREE;
    t_raddr         = scan_c_r[IW-1:0];
    b_we            = 1'b0;
    b_waddr         = fill_r[BW-1:0];
    b_wdata         = pend_c_r;
    b_raddr         = j_r[BW-1:0];

    unique case (state_r)
      S_CLR: begin
        t_we    = 1'b1;
        t_waddr = clr_r;
        clr_nxt = IW'(clr_r + 1'b1);
        if (clr_r == CLR_END) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        t_raddr = in_cluster_index[IW-1:0];
        if (accept) begin
          res_status_nxt  = ST_OK;
          res_cluster_nxt = LINK_FREE;
          res_rv_nxt      = LINK_FREE;
          freed_nxt       = '0;
          state_nxt       = S_EMIT;
          unique case (in_req_type)
            REQ_WRITE: begin
              if (!in_range) begin
                res_status_nxt = ST_RANGE;
              end else if (!cfg.writable) begin
                res_status_nxt = ST_READONLY;
              end else begin
                t_we    = 1'b1;
                t_waddr = in_cluster_index[IW-1:0];
                t_wdata = in_entry_value;
              end
            end
            REQ_READ: begin
              if (!in_range) begin
                res_status_nxt = ST_RANGE;
              end else begin
                state_nxt = S_RD;
              end
            end
            REQ_FIND: begin
              if (!in_range) begin
                res_status_nxt = ST_RANGE;
              end else begin
                alloc_nxt  = 1'b0;
                pend_nxt   = 1'b0;
                scan_c_nxt = (in_cluster_index < 16'd2) ? 17'd2 : 17'(in_cluster_index);
                state_nxt  = S_SCAN;
              end
            end
            REQ_ALLOC: begin
              if (!cfg.writable) begin
                res_status_nxt = ST_READONLY;
              end else if (in_chain_length > LEN_W'(MAX_CHAIN)) begin
                res_status_nxt = ST_TOOLONG;
              end else if (in_chain_length == '0) begin
                fill_nxt = '0;
              end else begin
                fill_nxt     = '0;
                len_nxt      = CW'(in_chain_length);
                has_prev_nxt = 1'b0;
                alloc_nxt    = 1'b1;
                pend_nxt     = 1'b0;
                scan_c_nxt   = 17'd2;
                state_nxt    = S_SCAN;
              end
            end
            REQ_FREE: begin
              if (!cfg.writable) begin
                res_status_nxt = ST_READONLY;
              end else begin
                walk_c_nxt = in_cluster_index[IW-1:0];
                byp_nxt    = 1'b0;
                case (walk_dec0)
                  W_GO:    state_nxt      = S_FWALK;
                  W_RANGE: res_status_nxt = ST_RANGE;
                  W_LONG:  res_status_nxt = ST_TOOLONG;
                  default: res_status_nxt = ST_OK;
                endcase
              end
            end
            default: begin
              res_status_nxt = ST_RANGE;
            end
          endcase
        end
      end

      S_RD: begin
        res_rv_nxt = t_rdata;
        state_nxt  = S_EMIT;
      end

      S_SCAN: begin
        if (hit) begin
          if (!alloc_r) begin
            res_status_nxt  = ST_OK;
            res_cluster_nxt = CLUS_W'(pend_c_r);
            state_nxt       = S_EMIT;
          end else begin
            t_we          = 1'b1;
            t_waddr       = pend_c_r;
            t_wdata       = EOC_MIN;
            b_we          = 1'b1;
            fill_nxt      = CW'(fill_r + 1'b1);
            link_from_nxt = prev_r;
            link_pend_nxt = has_prev_r;
            prev_nxt      = pend_c_r;
            has_prev_nxt  = 1'b1;
            state_nxt     = S_ANEXT;
          end
        end else if (scan_c_r >= lim) begin
          if (!alloc_r) begin
            res_status_nxt  = ST_NOSPACE;
            res_cluster_nxt = LINK_FREE;
            state_nxt       = S_EMIT;
          end else begin
            j_nxt     = '0;
            upend_nxt = 1'b0;
            state_nxt = S_UNDO;
          end
        end else begin
          pend_nxt   = 1'b1;
          pend_c_nxt = scan_c_r[IW-1:0];
          scan_c_nxt = 17'(scan_c_r + 1'b1);
        end
      end

      S_ANEXT: begin
        if (link_pend_r) begin
          t_we    = 1'b1;
          t_waddr = link_from_r;
          t_wdata = CLUS_W'(prev_r);
        end
        if (fill_r == len_r) begin
          state_nxt = S_AEND;
        end else begin
          scan_c_nxt = 17'(prev_r) + 17'd1;
          pend_nxt   = 1'b0;
          state_nxt  = S_SCAN;
        end
      end

      S_AEND: begin
        t_we      = 1'b1;
        t_waddr   = prev_r;
        t_wdata   = EOC_LAST;
        j_nxt     = '0;
        state_nxt = S_ORD;
      end

      S_UNDO: begin
        if (upend_r) begin
          t_we    = 1'b1;
          t_waddr = b_rdata;
          t_wdata = LINK_FREE;
        end
        if (j_r < fill_r) begin
          j_nxt     = CW'(j_r + 1'b1);
          upend_nxt = 1'b1;
        end else begin
          fill_nxt        = '0;
          res_status_nxt  = ST_NOSPACE;
          res_cluster_nxt = LINK_FREE;
          state_nxt       = S_EMIT;
        end
      end

      S_ORD: begin
        state_nxt = S_OEMIT;
      end

      S_OEMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_OK;
          out_cluster_nxt = CLUS_W'(b_rdata);
          out_rv_nxt      = LINK_FREE;
          out_freed_nxt   = '0;
          out_last_nxt    = out_is_last;
          j_nxt           = CW'(j_r + 1'b1);
          state_nxt       = out_is_last ? S_IDLE : S_ORD;
        end
      end

      S_FWALK: begin
        t_we      = 1'b1;
        t_waddr   = walk_c_r;
        t_wdata   = LINK_FREE;
        freed_nxt = freed_inc;
        t_raddr   = walk_data[IW-1:0];
        if (walk_dec == W_GO) begin
          walk_c_nxt = walk_data[IW-1:0];
          byp_nxt    = (walk_data[IW-1:0] == walk_c_r);
        end else begin
          case (walk_dec)
            W_RANGE: res_status_nxt = ST_RANGE;
            W_LONG:  res_status_nxt = ST_TOOLONG;
            default: res_status_nxt = ST_OK;
          endcase
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_cluster_nxt = res_cluster_r;
          out_rv_nxt      = res_rv_r;
          out_freed_nxt   = FREED_W'(freed_r);
          out_last_nxt    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      alloc_r     <= 1'b0;
      has_prev_r  <= 1'b0;
      link_pend_r <= 1'b0;
      fill_r      <= '0;
      len_r       <= '0;
      j_r         <= '0;
      upend_r     <= 1'b0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      alloc_r     <= alloc_nxt;
      has_prev_r  <= has_prev_nxt;
      link_pend_r <= link_pend_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      j_r         <= j_nxt;
      upend_r     <= upend_nxt;
      byp_r       <= byp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_c_r      <= scan_c_nxt;
    pend_c_r      <= pend_c_nxt;
    prev_r        <= prev_nxt;
    link_from_r   <= link_from_nxt;
    walk_c_r      <= walk_c_nxt;
    freed_r       <= freed_nxt;
    res_status_r  <= res_status_nxt;
    res_cluster_r <= res_cluster_nxt;
    res_rv_r      <= res_rv_nxt;
    out_status_r  <= out_status_nxt;
    out_cluster_r <= out_cluster_nxt;
    out_rv_r      <= out_rv_nxt;
    out_freed_r   <= out_freed_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_cluster = out_cluster_r;
  assign out_read_value     = out_rv_r;
  assign out_freed_count    = out_freed_r;
  assign out_last           = out_last_r;

endmodule

// File: hdl/fat_cluster_chain_allocator_core.sv
// Top level of the FAT16 cluster chain allocator: config registers, link table, chain buffer.
//
//   channel | direction | handshake          | beat
//   in_     | input     | in_valid/in_stall   | one request
//   out_    | output    | out_valid/out_stall | one result, out_last on the final one
//   cfg_    | input     | cfg_we              | one register write
//
// After reset a clearing pass zeroes the link table entry by entry, with in_stall high.
// Write entry writes the table on acceptance; read entry waits for the registered read. Find
// free reads one table entry per cycle from the hint to the scan limit. Allocate scans
// one entry per cycle, marks and links each cluster taken, closes the chain, then emits a
// result beat per cluster; a rollback frees each cluster taken. Free chain clears each link.
// One request at a time; out_stall holds the sequencer at its result.
module fat_cluster_chain_allocator_core #(
  parameter int TABLE_ENTRIES = fcca_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CHAIN     = fcca_pkg::MAX_CHAIN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [fcca_pkg::REQ_W-1:0]   in_req_type,
  input  logic [fcca_pkg::CLUS_W-1:0]  in_cluster_index,
  input  logic [fcca_pkg::CLUS_W-1:0]  in_entry_value,
  input  logic [fcca_pkg::LEN_W-1:0]   in_chain_length,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fcca_pkg::ST_W-1:0]    out_status,
  output logic [fcca_pkg::CLUS_W-1:0]  out_result_cluster,
  output logic [fcca_pkg::CLUS_W-1:0]  out_read_value,
  output logic [fcca_pkg::FREED_W-1:0] out_freed_count,
  output logic                         out_last,
  input  logic                         cfg_we,
  input  logic [fcca_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [fcca_pkg::CFG_W-1:0]   cfg_wdata
);

  import fcca_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int BW = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;

  cfg_t cfg_r;

  logic              t_we;
  logic [IW-1:0]     t_waddr;
  logic [CLUS_W-1:0] t_wdata;
  logic [IW-1:0]     t_raddr;
  logic [CLUS_W-1:0] t_rdata;
  logic              b_we;
  logic [BW-1:0]     b_waddr;
  logic [IW-1:0]     b_wdata;
  logic [BW-1:0]     b_raddr;
  logic [IW-1:0]     b_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.count    <= COUNT_RST;
      cfg_r.writable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COUNT:    cfg_r.count    <= cfg_wdata[COUNT_W-1:0];
        REG_WRITABLE: cfg_r.writable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  fcca_ram #(
    .WIDTH (CLUS_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_link_table (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  fcca_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_CHAIN)
  ) u_chain_buf (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  fcca_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_CHAIN     (MAX_CHAIN)
  ) u_engine (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_cluster_index   (in_cluster_index),
    .in_entry_value     (in_entry_value),
    .in_chain_length    (in_chain_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_result_cluster (out_result_cluster),
    .out_read_value     (out_read_value),
    .out_freed_count    (out_freed_count),
    .out_last           (out_last),
    .t_we               (t_we),
    .t_waddr            (t_waddr),
    .t_wdata            (t_wdata),
    .t_raddr            (t_raddr),
    .t_rdata            (t_rdata),
    .b_we               (b_we),
    .b_waddr            (b_waddr),
    .b_wdata            (b_wdata),
    .b_raddr            (b_raddr),
    .b_rdata            (b_rdata)
  );

endmodule

// File: tb/fat_cluster_chain_allocator_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the FAT16 cluster chain allocator core.
module fat_cluster_chain_allocator_core_tb;
  import fcca_pkg::*;

  localparam int QUIET_LIMIT = 40000;
  localparam logic [REQ_W-1:0] REQ_BAD_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_BAD_HI = 3'd7;

  typedef struct {
    logic [REQ_W-1:0]  req_type;
    logic [CLUS_W-1:0] cluster_index;
    logic [CLUS_W-1:0] entry_value;
    logic [LEN_W-1:0]  chain_length;
  } request_t;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [CLUS_W-1:0]  result_cluster;
    logic [CLUS_W-1:0]  read_value;
    logic [FREED_W-1:0] freed_count;
    logic               last;
  } result_t;

  class fat_table_tracker;
    logic [CLUS_W-1:0]  link_img [TABLE_ENTRIES_DEF];
    logic [COUNT_W-1:0] cluster_count;
    logic               table_writable;
    result_t            due_results[$];
    int unsigned        heads[$];
    int unsigned        errors;

    function new();
      foreach (link_img[i]) link_img[i] = LINK_FREE;
      cluster_count  = COUNT_RST;
      table_writable = 1'b1;
      errors         = 0;
    endfunction

    function void set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_COUNT) cluster_count = val[COUNT_W-1:0];
      else table_writable = val[0];
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void due(logic [ST_W-1:0] st, int unsigned clus, int unsigned rd,
                      int unsigned freed, logic last);
      result_t r;
      r.status         = st;
      r.result_cluster = clus[CLUS_W-1:0];
      r.read_value     = rd[CLUS_W-1:0];
      r.freed_count    = freed[FREED_W-1:0];
      r.last           = last;
      due_results = {due_results, r};
    endfunction

    function int unsigned first_free(int unsigned start);
      int unsigned lim;
      int unsigned c;
      lim = cluster_count + 32'd2;
      if (lim > TABLE_ENTRIES_DEF) lim = TABLE_ENTRIES_DEF;
      if (start < 2) start = 2;
      for (c = start; c < lim; c++)
        if (link_img[c] == LINK_FREE) return c;
      return 0;
    endfunction

    function void note_request(request_t r);
      int unsigned c;
      int unsigned nxt;
      int unsigned freed;
      int unsigned f;
      int unsigned prev;
      int unsigned n;
      int unsigned taken[$];
      logic [ST_W-1:0] st;
      case (r.req_type)
        REQ_WRITE: begin
          if (r.cluster_index >= TABLE_ENTRIES_DEF) due(ST_RANGE, 0, 0, 0, 1'b1);
          else if (!table_writable) due(ST_READONLY, 0, 0, 0, 1'b1);
          else begin
            link_img[r.cluster_index] = r.entry_value;
            due(ST_OK, 0, 0, 0, 1'b1);
          end
        end
        REQ_READ: begin
          if (r.cluster_index >= TABLE_ENTRIES_DEF) due(ST_RANGE, 0, 0, 0, 1'b1);
          else due(ST_OK, 0, link_img[r.cluster_index], 0, 1'b1);
        end
        REQ_FIND: begin
          if (r.cluster_index >= TABLE_ENTRIES_DEF) due(ST_RANGE, 0, 0, 0, 1'b1);
          else begin
            f = first_free(r.cluster_index);
            due((f != 0) ? ST_OK : ST_NOSPACE, f, 0, 0, 1'b1);
          end
        end
        REQ_ALLOC: begin
          if (!table_writable) due(ST_READONLY, 0, 0, 0, 1'b1);
          else if (r.chain_length > MAX_CHAIN_DEF) due(ST_TOOLONG, 0, 0, 0, 1'b1);
          else if (r.chain_length == 0) due(ST_OK, 0, 0, 0, 1'b1);
          else begin
            prev = 0;
            st = ST_OK;
            for (n = 0; n < r.chain_length; n++) begin
              f = first_free((prev != 0) ? prev + 1 : 2);
              if (f == 0) begin
                foreach (taken[k]) link_img[taken[k]] = LINK_FREE;
                st = ST_NOSPACE;
                break;
              end
              link_img[f] = EOC_MIN;
              if (prev != 0) link_img[prev] = 16'(f);
              taken = {taken, f};
              prev = f;
            end
            if (st == ST_NOSPACE) due(ST_NOSPACE, 0, 0, 0, 1'b1);
            else begin
              link_img[prev] = EOC_LAST;
              heads = {heads, taken[0]};
              foreach (taken[k]) due(ST_OK, taken[k], 0, 0, k == taken.size() - 1);
            end
          end
        end
        REQ_FREE: begin
          if (!table_writable) due(ST_READONLY, 0, 0, 0, 1'b1);
          else begin
            c = r.cluster_index;
            freed = 0;
            st = ST_OK;
            while (c >= 2 && c < EOC_MIN) begin
              if (c >= TABLE_ENTRIES_DEF) begin
                st = ST_RANGE;
                break;
              end
              if (freed >= TABLE_ENTRIES_DEF) begin
                st = ST_TOOLONG;
                break;
              end
              nxt = link_img[c];
              link_img[c] = LINK_FREE;
              freed++;
              if (nxt >= EOC_MIN) break;
              c = nxt;
            end
            due(st, 0, 0, freed, 1'b1);
          end
        end
        default: due(ST_RANGE, 0, 0, 0, 1'b1);
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: st %0d clus %h rd %h freed %0d last %b",
                   got.status, got.result_cluster, got.read_value, got.freed_count, got.last);
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status || got.result_cluster !== want.result_cluster ||
          got.read_value !== want.read_value || got.freed_count !== want.freed_count ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch: expected st %0d clus %h rd %h freed %0d last %b",
                   want.status, want.result_cluster, want.read_value, want.freed_count,
                   want.last);
          $display("                 actual   st %0d clus %h rd %h freed %0d last %b",
                   got.status, got.result_cluster, got.read_value, got.freed_count, got.last);
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [REQ_W-1:0]    in_req_type = '0;
  logic [CLUS_W-1:0]   in_cluster_index = '0;
  logic [CLUS_W-1:0]   in_entry_value = '0;
  logic [LEN_W-1:0]    in_chain_length = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ST_W-1:0]     out_status;
  logic [CLUS_W-1:0]   out_result_cluster;
  logic [CLUS_W-1:0]   out_read_value;
  logic [FREED_W-1:0]  out_freed_count;
  logic                out_last;
  logic                cfg_we = 1'b0;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  fat_table_tracker sb = new();
  logic        no_gaps = 1'b0;
  int unsigned out_wait = 0;
  int unsigned quiet_cycles = 0;

  fat_cluster_chain_allocator_core i_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result({out_status, out_result_cluster, out_read_value, out_freed_count,
                       out_last});
      out_wait = no_gaps ? 0 : $urandom_range(0, 3);
    end else if (out_wait != 0) begin
      out_wait = out_wait - 1;
    end
    out_stall <= (out_wait != 0);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("fat_cluster_chain_allocator_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic issue(input request_t r);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= r.req_type;
    in_cluster_index <= r.cluster_index;
    in_entry_value   <= r.entry_value;
    in_chain_length  <= r.chain_length;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic send(input logic [REQ_W-1:0] kind, input logic [CLUS_W-1:0] idx,
                      input logic [CLUS_W-1:0] val, input logic [LEN_W-1:0] len);
    request_t r;
    r = '{kind, idx, val, len};
    issue(r);
  endtask

  // hold the sender until every result beat is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic program_regs(input logic [COUNT_W-1:0] count, input logic writable);
    logic [CFG_W-1:0] wr_word;
    wr_word = {{(CFG_W-1){1'b0}}, writable};
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_COUNT;
    cfg_wdata <= count;
    @(posedge clk);
    sb.set_reg(REG_COUNT, count);
    cfg_index <= REG_WRITABLE;
    cfg_wdata <= wr_word;
    @(posedge clk);
    sb.set_reg(REG_WRITABLE, wr_word);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CLUS_W-1:0] near_index(int unsigned hi);
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, hi));
  endfunction

  function automatic request_t random_request();
    request_t    r;
    int unsigned hi;
    int unsigned pick;
    int unsigned sub;
    int unsigned k;
    hi = sb.cluster_count + 32'd3;
    if (hi > TABLE_ENTRIES_DEF - 1) hi = TABLE_ENTRIES_DEF - 1;
    r.req_type      = REQ_READ;
    r.cluster_index = 16'($urandom);
    r.entry_value   = 16'($urandom);
    r.chain_length  = 7'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 32) begin
      r.req_type = REQ_ALLOC;
      sub = $urandom_range(0, 19);
      if (sub == 0) r.chain_length = 7'($urandom_range(MAX_CHAIN_DEF + 1, 127));
      else if (sub == 1) r.chain_length = '0;
      else if (sub == 2) r.chain_length = 7'($urandom_range(20, MAX_CHAIN_DEF));
      else r.chain_length = 7'($urandom_range(1, 8));
    end else if (pick < 52) begin
      r.req_type = REQ_FREE;
      if (sb.heads.size() != 0 && $urandom_range(0, 4) != 0) begin
        k = $urandom_range(0, sb.heads.size() - 1);
        r.cluster_index = 16'(sb.heads[k]);
        sb.heads.delete(k);
      end else begin
        r.cluster_index = near_index(hi);
      end
    end else if (pick < 67) begin
      r.cluster_index = near_index(hi);
    end else if (pick < 77) begin
      r.req_type = REQ_FIND;
      r.cluster_index = near_index(hi);
    end else if (pick < 90) begin
      r.req_type = REQ_WRITE;
      r.cluster_index = near_index(hi);
      case ($urandom_range(0, 4))
        0: r.entry_value = LINK_FREE;
        1: r.entry_value = EOC_LAST;
        2: r.entry_value = 16'($urandom_range(EOC_MIN, EOC_LAST));
        3: r.entry_value = 16'($urandom_range(0, hi));
        default: ;
      endcase
    end else begin
      r.req_type = 3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
    end
    return r;
  endfunction

  task automatic random_phase(input logic [COUNT_W-1:0] count, input logic writable,
                              input int unsigned beats, input logic gapless);
    program_regs(count, writable);
    no_gaps = gapless;
    repeat (beats) begin
      issue(random_request());
      if ($urandom_range(0, 29) == 0) wait_idle();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send(REQ_WRITE, 16'd0, EOC_LAST, 7'd0);
    send(REQ_WRITE, 16'd1, 16'h1234, 7'd0);
    send(REQ_READ, 16'd1, 16'h0, 7'd0);
    send(REQ_WRITE, 16'd4095, 16'hA5A5, 7'd127);
    send(REQ_READ, 16'd4095, 16'hFFFF, 7'd0);
    send(REQ_WRITE, 16'd4096, 16'd5, 7'd0);
    send(REQ_READ, 16'hFFFF, 16'h0, 7'd0);
    send(REQ_FIND, 16'd0, 16'h0, 7'd0);
    send(REQ_FIND, 16'd4095, 16'h0, 7'd0);
    send(REQ_FIND, 16'hFFFF, 16'h0, 7'd0);
    send(REQ_ALLOC, 16'd0, 16'h0, 7'd0);
    send(REQ_ALLOC, 16'd0, 16'h0, 7'd65);
    send(REQ_ALLOC, 16'hFFFF, 16'hFFFF, 7'd127);
    send(REQ_ALLOC, 16'd0, 16'h0, 7'd64);
    send(REQ_ALLOC, 16'd0, 16'h0, 7'd3);
    send(REQ_FREE, 16'd2, 16'h0, 7'd0);
    send(REQ_FREE, 16'd0, 16'h0, 7'd0);
    send(REQ_FREE, 16'hFFFF, 16'h0, 7'd0);
    send(REQ_WRITE, 16'd100, 16'h2000, 7'd0);
    send(REQ_FREE, 16'd100, 16'h0, 7'd0);
    send(REQ_FREE, 16'h1000, 16'h0, 7'd0);
    send(REQ_BAD_LO, 16'd2, 16'h0, 7'd0);
    send(REQ_BAD_HI, 16'd2, 16'h0, 7'd0);

    program_regs(12'd0, 1'b1);
    send(REQ_FIND, 16'd0, 16'h0, 7'd0);
    send(REQ_ALLOC, 16'd0, 16'h0, 7'd1);
    send(REQ_READ, 16'd0, 16'h0, 7'd0);

    program_regs(12'd5, 1'b1);
    send(REQ_ALLOC, 16'd0, 16'h0, 7'd4);
    send(REQ_ALLOC, 16'd0, 16'h0, 7'd3);
    send(REQ_READ, 16'd6, 16'h0, 7'd0);
    send(REQ_ALLOC, 16'd0, 16'h0, 7'd1);

    program_regs(12'd4095, 1'b0);
    send(REQ_WRITE, 16'd7, 16'h0001, 7'd0);
    send(REQ_WRITE, 16'h8000, 16'h0001, 7'd0);
    send(REQ_ALLOC, 16'd0, 16'h0, 7'd4);
    send(REQ_ALLOC, 16'd0, 16'h0, 7'd100);
    send(REQ_FREE, 16'd2, 16'h0, 7'd0);
    send(REQ_FIND, 16'd2, 16'h0, 7'd0);

    random_phase(12'd12, 1'b1, 25, 1'b0);
    random_phase(12'd40, 1'b1, 30, 1'b1);
    random_phase(12'd4095, 1'b1, 20, 1'b0);
    random_phase(12'd60, 1'b0, 10, 1'b0);
    random_phase(12'($urandom_range(20, 200)), 1'b1, 19, 1'b0);

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("fat_cluster_chain_allocator_core verification clean");
    end else begin
      $display("fat_cluster_chain_allocator_core verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/fcca_pkg.sv
hdl/fcca_ram.sv
hdl/fcca_engine.sv
hdl/fat_cluster_chain_allocator_core.sv
tb/fat_cluster_chain_allocator_core_tb.sv
